// File: design/smre_pkg.sv
`timescale 1ns / 1ps
package smre_pkg;

    localparam int VALUE_W  = 32;
    localparam int ANSWER_W = 39;

    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic signed [ANSWER_W-1:0] answer_t;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_RANK   = 3'd2;
    localparam logic [2:0] CMD_KTH    = 3'd3;
    localparam logic [2:0] CMD_SUM    = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

endpackage

// File: design/smre_cell.sv
`timescale 1ns / 1ps
module smre_cell
    import smre_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  value_t din,
    output value_t q
);

    value_t val_reg;
    value_t val_next;

    always_comb
    begin
        val_next = shift ? din : val_reg;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

// File: design/sorted_multiset_rank_engine.sv
`timescale 1ns / 1ps
// Every command rotates the whole cell ring once in ST_RUN, then passes through ST_FINISH.
// The result is registered in ST_FINISH once the output register is free; a new command
// is taken only in ST_IDLE, so none is accepted until the previous one is finished.
// A finished result waits in the output register while the next command runs.
// Reset clears the entry count and handshake state; cell contents are left as they are.
module sorted_multiset_rank_engine
    import smre_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int CntW = $clog2(CAPACITY + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  logic [2:0]      cmd,
    input  value_t          value,
    input  logic [CntW-1:0] k,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output answer_t         answer,
    output logic [1:0]      status,
    output logic [CntW-1:0] occupancy
);

    localparam int IdxW = $clog2(CAPACITY);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
    localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // entry j sits in cell CAPACITY-1-j when the ring is at rest
    value_t cell_q [CAPACITY];
    value_t feed;
    logic   shift;

    logic [1:0]      state_reg, state_next;
    logic [2:0]      cmd_reg, cmd_next;
    value_t          value_reg, value_next;
    logic [CntW-1:0] k_reg, k_next;
    logic [CntW-1:0] start_reg, start_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [IdxW-1:0] t_reg, t_next;
    logic            done_reg, done_next;
    value_t          pend_reg, pend_next;
    answer_t         acc_reg, acc_next;

    logic            rsp_valid_reg, rsp_valid_next;
    answer_t         answer_reg, answer_next;
    logic [1:0]      status_reg, status_next;
    logic [CntW-1:0] occ_reg, occ_next;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                smre_cell u_cell (.clk(clk), .shift(shift), .din(feed), .q(cell_q[gi]));
            end
            else
            begin : g_body
                smre_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[gi-1]), .q(cell_q[gi]));
            end
        end
    endgenerate

    assign shift = (state_reg == ST_RUN);

    always_comb
    begin
        value_t          tail;
        value_t          ahead;
        logic            live;
        logic            full;
        logic            hit;
        logic            rsp_free;
        logic [CntW-1:0] take;

        tail     = cell_q[CAPACITY-1];
        ahead    = cell_q[CAPACITY-2];
        live     = CntW'(t_reg) < count_reg;
        full     = (count_reg == CapCnt);
        hit      = 1'b0;
        rsp_free = !rsp_valid_reg || !rsp_stall;
        take     = (k < count_reg) ? k : count_reg;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        t_next         = t_reg;
        done_next      = done_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        feed           = tail;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        answer_next    = answer_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    value_next = value;
                    k_next     = k;
                    start_next = count_reg - take;
                    t_next     = '0;
                    done_next  = 1'b0;
                    acc_next   = (cmd == CMD_RANK) ? answer_t'(1) : '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (!full)
                        begin
                            if (done_reg)
                            begin
                                feed      = pend_reg;
                                pend_next = tail;
                            end
                            else if (!(live && tail <= value_reg))
                            begin
                                feed      = value_reg;
                                pend_next = tail;
                                done_next = 1'b1;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        // first equal copy drops out; the rest close up from the next cell
                        hit = !done_reg && live && (tail == value_reg);
                        if (done_reg || hit)
                        begin
                            feed      = ahead;
                            done_next = 1'b1;
                        end
                    end
                    CMD_RANK:
                    begin
                        if (live && tail < value_reg)
                        begin
                            acc_next = acc_reg + answer_t'(1);
                        end
                    end
                    CMD_KTH:
                    begin
                        if (CntW'(t_reg) + CntW'(1) == k_reg)
                        begin
                            acc_next = ANSWER_W'(tail);
                        end
                    end
                    CMD_SUM:
                    begin
                        if (live && CntW'(t_reg) >= start_reg)
                        begin
                            acc_next = acc_reg + ANSWER_W'(tail);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                t_next = t_reg + IdxW'(1);
                if (t_reg == LastIdx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    answer_next = '0;
                    status_next = STAT_OK;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CntW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (done_reg)
                            begin
                                count_next = count_reg - CntW'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                        CMD_RANK:
                        begin
                            answer_next = acc_reg;
                        end
                        CMD_KTH:
                        begin
                            if (k_reg == '0 || k_reg > count_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                answer_next = acc_reg;
                            end
                        end
                        CMD_SUM:
                        begin
                            answer_next = acc_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    occ_next       = count_next;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            t_reg         <= '0;
            done_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            t_reg         <= t_next;
            done_reg      <= done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        k_reg      <= k_next;
        start_reg  <= start_next;
        pend_reg   <= pend_next;
        acc_reg    <= acc_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule
